// File: rtl/gbn_pkg.sv
// Shared types and constants for the go-back-N sender window unit.
package gbn_pkg;

    localparam int REQ_W = 2;
    localparam int SEQ_W = 8;
    localparam int WIN_W = 4;
    localparam int MOD_W = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_NEW  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ACK  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b1;

    // Register reset values and modulus clamp limits
    localparam logic [WIN_W-1:0] WINDOW_RESET  = 4'd4;
    localparam logic [MOD_W-1:0] MODULUS_RESET = 9'd100;
    localparam logic [MOD_W-1:0] MODULUS_MIN   = 9'd2;
    localparam logic [MOD_W-1:0] MODULUS_MAX   = 9'd256;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;
    } ctrl_sts_t;

    // Successor of a sequence number under an already clamped modulus
    function automatic logic [SEQ_W-1:0] seq_succ(input logic [SEQ_W-1:0] s,
                                                  input logic [MOD_W-1:0] m);
        logic [MOD_W-1:0] p;
        begin
            p = {1'b0, s} + 9'd1;
            return (p >= m) ? '0 : p[SEQ_W-1:0];
        end
    endfunction

endpackage

// File: rtl/gbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/gbn_ctrl.sv
// Controller: accepts one word, then executes it once the output register is free.
module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      cfg_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance on accept, return once the result is loaded
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Drive handshake and commands
    always_comb
    begin
        in_stall  = 1'b1;
        cfg_ready = 1'b0;
        cmd.load  = 1'b0;
        cmd.exec  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cfg_ready = 1'b1;
                cmd.load  = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = !sts.out_busy;
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/gbn_dp.sv
// Datapath: window counters, sequence ring, configuration and output register.
module gbn_dp
    import gbn_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ctrl_cmd_t                          cmd,
    output ctrl_sts_t                          sts,
    input  logic [REQ_W-1:0]                   req_type,
    input  logic [SEQ_W-1:0]                   ack_value,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [CFG_IDX_W-1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]              cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               send_valid,
    output logic [SEQ_W-1:0]                   send_seq,
    output logic                               ack_matched,
    output logic                               went_back,
    output logic                               overflow,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queued,
    output logic [WIN_W-1:0]                   in_flight
);

    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > WIN_W) ? CW : WIN_W;

    // Control state
    logic [PW-1:0]    head_reg, head_next;
    logic [CW-1:0]    queue_reg, queue_next;
    logic [WIN_W-1:0] sent_reg, sent_next;
    logic [SEQ_W-1:0] nseq_reg, nseq_next;
    logic [WIN_W-1:0] window_reg;
    logic [MOD_W-1:0] modulus_reg;
    logic             out_valid_reg, out_valid_next;

    // Captured word and result payload
    logic [REQ_W-1:0] req_reg;
    logic [SEQ_W-1:0] ack_reg;
    logic             sv_reg, am_reg, wb_reg, ov_reg;
    logic [SEQ_W-1:0] ss_reg;

    logic             sv, am, wb, ov;
    logic [SEQ_W-1:0] ss;
    logic [MOD_W-1:0] mod_eff;
    logic [REQ_W-1:0] rd_req;
    logic             ram_we;
    logic [PW-1:0]    ram_waddr, ram_raddr;
    logic [SEQ_W-1:0] ram_rdata;
    logic             can_send, ack_hit;

    // Ring position of an offset from the head; offset is at most the depth
    function automatic logic [PW-1:0] ring_index(input logic [PW-1:0] base,
                                                 input logic [CW-1:0] off);
        logic [CW:0] s;
        begin
            s = {{(CW + 1 - PW){1'b0}}, base} + {1'b0, off};
            if (s >= (CW + 1)'(QUEUE_DEPTH))
            begin
                s = s - (CW + 1)'(QUEUE_DEPTH);
            end
            return s[PW-1:0];
        end
    endfunction

    gbn_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (nseq_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clamp the modulus into its usable range
    always_comb
    begin
        if (modulus_reg < MODULUS_MIN)
        begin
            mod_eff = MODULUS_MIN;
        end
        else if (modulus_reg > MODULUS_MAX)
        begin
            mod_eff = MODULUS_MAX;
        end
        else
        begin
            mod_eff = modulus_reg;
        end
    end

    // Address the ring: next unsent entry for a send, head otherwise
    assign rd_req    = cmd.load ? req_type : req_reg;
    assign ram_raddr = (rd_req == REQ_SEND) ? ring_index(head_reg, CW'(sent_reg)) : head_reg;
    assign ram_waddr = ring_index(head_reg, queue_reg);

    assign can_send = (queue_reg != '0) && (sent_reg < window_reg)
                      && (CMPW'(sent_reg) < CMPW'(queue_reg));
    assign ack_hit  = (queue_reg != '0) && (ack_reg == seq_succ(ram_rdata, mod_eff));

    // Execute the captured word
    always_comb
    begin
        head_next  = head_reg;
        queue_next = queue_reg;
        sent_next  = sent_reg;
        nseq_next  = nseq_reg;
        ram_we     = 1'b0;
        sv         = 1'b0;
        ss         = '0;
        am         = 1'b0;
        wb         = 1'b0;
        ov         = 1'b0;
        if (cmd.exec)
        begin
            case (req_reg)
                REQ_NEW:
                begin
                    if (queue_reg == CW'(QUEUE_DEPTH))
                    begin
                        ov = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        queue_next = queue_reg + 1'b1;
                        nseq_next  = seq_succ(nseq_reg, mod_eff);
                    end
                end
                REQ_SEND:
                begin
                    if (can_send)
                    begin
                        sv        = 1'b1;
                        ss        = ram_rdata;
                        sent_next = sent_reg + 1'b1;
                    end
                end
                REQ_ACK:
                begin
                    if (ack_hit)
                    begin
                        am         = 1'b1;
                        head_next  = ring_index(head_reg, CW'(1));
                        queue_next = queue_reg - 1'b1;
                        if (sent_reg != '0)
                        begin
                            sent_next = sent_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        wb        = 1'b1;
                        sent_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Load the output register on execute, drop it once taken
    always_comb
    begin
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign sts.out_busy = out_valid_reg && out_stall;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            queue_reg     <= '0;
            sent_reg      <= '0;
            nseq_reg      <= '0;
            window_reg    <= WINDOW_RESET;
            modulus_reg   <= MODULUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            queue_reg     <= queue_next;
            sent_reg      <= sent_next;
            nseq_reg      <= nseq_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_WINDOW:  window_reg  <= cfg_data[WIN_W-1:0];
                    CFG_MODULUS: modulus_reg <= cfg_data[MOD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            ack_reg <= ack_value;
        end
        if (cmd.exec)
        begin
            sv_reg <= sv;
            ss_reg <= ss;
            am_reg <= am;
            wb_reg <= wb;
            ov_reg <= ov;
        end
    end

    assign out_valid   = out_valid_reg;
    assign send_valid  = sv_reg;
    assign send_seq    = ss_reg;
    assign ack_matched = am_reg;
    assign went_back   = wb_reg;
    assign overflow    = ov_reg;
    assign queued      = queue_reg;
    assign in_flight   = sent_reg;

    // The queue never holds more than the ring
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        queue_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond ring depth");

    // A retired head shrinks the queue by exactly one
    a_retire: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && am |=> queue_reg == $past(queue_reg) - 1'b1)
        else $error("retire did not shrink queue");

    // A dropped packet leaves the queue and the sequence counter alone
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && ov |=> $stable(queue_reg) && $stable(nseq_reg))
        else $error("dropped packet changed state");

    // Execute always presents a result
    a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("executed word produced no result");

endmodule

// File: rtl/go_back_n_sender_window_unit.sv
// Top level of the go-back-N sender window unit.
//
//  Channel  Direction  Handshake               Payload
//  in       into       in_valid / in_stall     req_type, ack_value
//  out      out of     out_valid / out_stall   send_valid, send_seq, ack_matched,
//                                              went_back, overflow, queued, in_flight
//  cfg      into       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each word is accepted in idle, where the ring is read at the accept edge, and the
// state update and result load happen in execute; the next word is accepted only
// once the last one has executed, due to the registered read of the sequence ring.
// Reset clears the counters, sets window 4 and modulus 100; ring contents are
// undefined until written and need no clearing pass.
// A stalled output holds its result; the next word may be accepted meanwhile
// and then waits in execute, with the input stalled, until the result is taken.
module go_back_n_sender_window_unit
    import gbn_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [REQ_W-1:0]                   req_type,
    input  logic [SEQ_W-1:0]                   ack_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               send_valid,
    output logic [SEQ_W-1:0]                   send_seq,
    output logic                               ack_matched,
    output logic                               went_back,
    output logic                               overflow,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queued,
    output logic [WIN_W-1:0]                   in_flight,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [CFG_IDX_W-1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]              cfg_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    gbn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gbn_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .ack_value   (ack_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .send_valid  (send_valid),
        .send_seq    (send_seq),
        .ack_matched (ack_matched),
        .went_back   (went_back),
        .overflow    (overflow),
        .queued      (queued),
        .in_flight   (in_flight)
    );

endmodule
